// ===== rtl/cqam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqam_pkg
// Shared types and constants for the circular request queue with lookup.
// ----------------------------------------------------------------------------
package cqam_pkg;

  localparam int unsigned FIELD_ADDR_W = 64;
  localparam int unsigned SLOT_W       = 5;
  localparam int unsigned OP_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic cmp_full;
    logic find_empty;
  } cell_ctl_t;

endpackage : cqam_pkg
`default_nettype wire

// ===== rtl/cqam_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqam_in_if / cqam_out_if
// Valid/ready channels for queue requests and their results.
// ----------------------------------------------------------------------------
interface cqam_in_if import cqam_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [FIELD_ADDR_W-1:0] line_address;
  logic [FIELD_ADDR_W-1:0] byte_address;
  logic [SLOT_W-1:0]       remove_index;

  modport source (output valid, op, line_address, byte_address, remove_index,
                  input ready);
  modport sink   (input valid, op, line_address, byte_address, remove_index,
                  output ready);
endinterface : cqam_in_if

interface cqam_out_if import cqam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic              no_free_slot;

  modport source (output valid, found, slot, no_free_slot, input ready);
  modport sink   (input valid, found, slot, no_free_slot, output ready);
endinterface : cqam_out_if
`default_nettype wire

// ===== rtl/cqam_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cqam_cell
// One queue entry with its key compare and a scan token passed along the ring.
// ----------------------------------------------------------------------------
module cqam_cell import cqam_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 5,
  parameter int AW  = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cell_ctl_t     ctl,
  input  wire logic [IW-1:0] start_idx,
  input  wire logic          token_in,
  input  wire logic [AW-1:0] key_line,
  input  wire logic [AW-1:0] key_byte,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_line,
  input  wire logic [AW-1:0] wr_byte,
  output logic               token_out,
  output logic               hit
);

  logic [AW-1:0] line_r, line_nxt;
  logic [AW-1:0] byte_r, byte_nxt;
  logic          token_r, token_nxt;
  logic          flag;

  always_comb begin
    line_nxt  = wr_en ? wr_line : line_r;
    byte_nxt  = wr_en ? wr_byte : byte_r;
    token_nxt = token_r;
    if (ctl.load) begin
      token_nxt = (start_idx == IW'(IDX));
    end else if (ctl.advance) begin
      token_nxt = token_in;
    end
  end

  always_comb begin
    if (ctl.find_empty) begin
      flag = (line_r == '0);
    end else if (ctl.cmp_full) begin
      flag = (byte_r == key_byte);
    end else begin
      flag = (line_r == key_line);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r  <= '0;
      byte_r  <= '0;
      token_r <= 1'b0;
    end else begin
      line_r  <= line_nxt;
      byte_r  <= byte_nxt;
      token_r <= token_nxt;
    end
  end

  assign token_out = token_r;
  assign hit       = token_r & flag;

endmodule : cqam_cell
`default_nettype wire

// ===== rtl/circular_queue_address_match.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_address_match
// Ring of request entries with in-order associative lookup, add and remove.
// ----------------------------------------------------------------------------
// Requests enter on in_chan (valid/ready): op selects lookup, add or remove.
// Each request yields one result on out_chan: found, slot and no_free_slot.
// cfg_wr_en/cfg_wr_data set the compare mode (byte or line address); write
// it only while the queue is idle.
// A token walks the row of entry cells one cell per cycle, starting at head
// for a lookup and at tail for an add, and stops at the first cell that hits.
// A remove finishes without moving the token; lookup and add move it past
// up to QUEUE_DEPTH - 1 cells before the result is registered, and a
// lookup on an empty ring finishes without moving it.
// A new request is taken only while no scan is running; one result may
// wait in the output register.
// Reset clears all entries, head, tail, count, compare mode and out valid.
// When the receiver stalls, a finished scan holds until the output register
// frees; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module circular_queue_address_match import cqam_pkg::*; #(
  parameter int QUEUE_DEPTH   = 32,
  parameter int ADDRESS_WIDTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data,
  cqam_in_if.sink     in_chan,
  cqam_out_if.source  out_chan
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = ADDRESS_WIDTH;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    next_idx = (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic              cmp_full_r, cmp_full_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [AW-1:0]     key_line_r, key_line_nxt;
  logic [AW-1:0]     key_byte_r, key_byte_nxt;
  logic [SLOT_W-1:0] ridx_r, ridx_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [NW-1:0]     n_r, n_nxt;
  logic [NW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic              out_nofree_r, out_nofree_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   hit_eff;
  logic                   fin;
  logic                   commit;
  logic                   rm_ok;
  logic [NW-1:0]          lookup_len;
  logic [IW-1:0]          start_idx;
  cell_ctl_t              ctl;
  logic [QUEUE_DEPTH-1:0] tok;
  logic [QUEUE_DEPTH-1:0] hit_vec;
  logic                   wr_any;
  logic [IW-1:0]          wr_idx;
  logic [AW-1:0]          wr_line;
  logic [AW-1:0]          wr_byte;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign hit_eff  = (|hit_vec) && (n_r != '0);
  assign fin      = (state_r == ST_SCAN) &&
                    ((n_r == '0) || hit_eff || (NW'(k_r) == n_r - NW'(1)));
  assign commit   = fin && out_free;
  assign rm_ok    = int'(ridx_r) < QUEUE_DEPTH;

  always_comb begin
    if (head_r < tail_r) begin
      lookup_len = NW'(tail_r) - NW'(head_r);
    end else if (head_r == tail_r && count_r == '0) begin
      lookup_len = '0;
    end else begin
      lookup_len = NW'(QUEUE_DEPTH) - NW'(head_r) + NW'(tail_r);
    end
  end

  assign start_idx = (in_chan.op == OP_ADD) ? tail_r : head_r;

  always_comb begin
    ctl.load       = in_acc;
    ctl.advance    = (state_r == ST_SCAN) && !fin;
    ctl.cmp_full   = cmp_full_r;
    ctl.find_empty = (op_r == OP_ADD);
  end

  // entry writes: fill on add, clear on remove
  always_comb begin
    wr_any  = 1'b0;
    wr_idx  = idx_r;
    wr_line = key_line_r;
    wr_byte = key_byte_r;
    if (commit && op_r == OP_ADD && hit_eff) begin
      wr_any = 1'b1;
    end else if (commit && op_r == OP_REMOVE && rm_ok) begin
      wr_any  = 1'b1;
      wr_idx  = IW'(ridx_r);
      wr_line = '0;
      wr_byte = '0;
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    cqam_cell #(
      .IDX (g),
      .IW  (IW),
      .AW  (AW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .start_idx (start_idx),
      .token_in  (tok[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
      .key_line  (key_line_r),
      .key_byte  (key_byte_r),
      .wr_en     (wr_any && (wr_idx == IW'(g))),
      .wr_line   (wr_line),
      .wr_byte   (wr_byte),
      .token_out (tok[g]),
      .hit       (hit_vec[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cmp_full_nxt   = cfg_wr_en ? cfg_wr_data : cmp_full_r;
    op_nxt         = op_r;
    key_line_nxt   = key_line_r;
    key_byte_nxt   = key_byte_r;
    ridx_nxt       = ridx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_found_nxt  = out_found_r;
    out_slot_nxt   = out_slot_r;
    out_nofree_nxt = out_nofree_r;

    if (in_acc) begin
      state_nxt    = ST_SCAN;
      op_nxt       = in_chan.op;
      key_line_nxt = in_chan.line_address[AW-1:0];
      key_byte_nxt = in_chan.byte_address[AW-1:0];
      ridx_nxt     = in_chan.remove_index;
      idx_nxt      = start_idx;
      k_nxt        = '0;
      case (in_chan.op)
        OP_LOOKUP: n_nxt = lookup_len;
        OP_ADD:    n_nxt = NW'(QUEUE_DEPTH);
        default:   n_nxt = '0;
      endcase
    end else if (ctl.advance) begin
      idx_nxt = next_idx(idx_r);
      k_nxt   = k_r + IW'(1);
    end

    if (commit) begin
      state_nxt      = ST_IDLE;
      out_valid_nxt  = 1'b1;
      out_found_nxt  = 1'b0;
      out_slot_nxt   = '0;
      out_nofree_nxt = 1'b0;
      case (op_r)
        OP_LOOKUP: begin
          out_found_nxt = hit_eff;
          out_slot_nxt  = hit_eff ? SLOT_W'(idx_r) : '0;
        end
        OP_ADD: begin
          if (hit_eff) begin
            out_slot_nxt = SLOT_W'(idx_r);
            tail_nxt     = next_idx(idx_r);
            if (count_r != NW'(QUEUE_DEPTH)) begin
              count_nxt = count_r + NW'(1);
            end
          end else begin
            out_nofree_nxt = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (rm_ok) begin
            if (count_r != '0) begin
              count_nxt = count_r - NW'(1);
            end
            if (IW'(ridx_r) == head_r) begin
              head_nxt = next_idx(head_r);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_full_r  <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_full_r  <= cmp_full_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_line_r   <= key_line_nxt;
    key_byte_r   <= key_byte_nxt;
    ridx_r       <= ridx_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    out_found_r  <= out_found_nxt;
    out_slot_r   <= out_slot_nxt;
    out_nofree_r <= out_nofree_nxt;
  end

  assign in_chan.ready         = (state_r == ST_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.found        = out_found_r;
  assign out_chan.slot         = out_slot_r;
  assign out_chan.no_free_slot = out_nofree_r;

  a_token_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one scan token in the ring");

  a_token_at_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> tok[idx_r])
    else $error("scan token and scan index disagree");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN) && !in_chan.ready)
    else $error("accepted request did not start a scan");

endmodule : circular_queue_address_match
`default_nettype wire
